[rtl/core/rbs_pkg.sv]
// Package with the types and constants shared by the ring byte buffer files.
package rbs_pkg;

    // Store geometry; the field widths of the channels are fixed to this depth.
    localparam int ADDR_W = 12;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int CNT_W  = ADDR_W + 1;

    // Operation codes carried in the op field of a request.
    localparam logic [2:0] OP_WRITE_BYTE   = 3'd0;
    localparam logic [2:0] OP_COMMIT_WRITE = 3'd1;
    localparam logic [2:0] OP_PEEK_BYTE    = 3'd2;
    localparam logic [2:0] OP_COMMIT_READ  = 3'd3;
    localparam logic [2:0] OP_READ_SPANS   = 3'd4;
    localparam logic [2:0] OP_WRITE_SPANS  = 3'd5;

    // One request as it travels inside the block.
    typedef struct packed {
        logic [2:0]        op;
        logic [ADDR_W-1:0] offset;
        logic [CNT_W-1:0]  count;
        logic [7:0]        data_in;
    } req_t;

    // One result as it travels inside the block.
    typedef struct packed {
        logic              ok;
        logic [7:0]        data_out;
        logic [ADDR_W-1:0] filled;
        logic [CNT_W-1:0]  free_space;
        logic [1:0]        span_count;
        logic [ADDR_W-1:0] span_start;
        logic [CNT_W-1:0]  first_len;
        logic [ADDR_W-1:0] second_len;
    } rsp_t;

    // Access command from the pointer logic to the byte store.
    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } mem_cmd_t;

endpackage

[rtl/core/rbs_if.sv]
// Request and result channel interfaces of the ring byte buffer.
interface rbs_req_if
    import rbs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [2:0]        op;
    logic [ADDR_W-1:0] offset;
    logic [CNT_W-1:0]  count;
    logic [7:0]        data_in;

    modport source (output valid, op, offset, count, data_in, input ready);
    modport sink   (input valid, op, offset, count, data_in, output ready);
endinterface

interface rbs_rsp_if
    import rbs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              ok;
    logic [7:0]        data_out;
    logic [ADDR_W-1:0] filled;
    logic [CNT_W-1:0]  free_space;
    logic [1:0]        span_count;
    logic [ADDR_W-1:0] span_start;
    logic [CNT_W-1:0]  first_len;
    logic [ADDR_W-1:0] second_len;

    modport source (output valid, ok, data_out, filled, free_space, span_count,
                    span_start, first_len, second_len, input ready);
    modport sink   (input valid, ok, data_out, filled, free_space, span_count,
                    span_start, first_len, second_len, output ready);
endinterface

[rtl/core/rbs_mem.sv]
// Byte store of the ring: one access per cycle, registered read data.
module rbs_mem
    import rbs_pkg::*;
(
    input  logic     clk,
    input  mem_cmd_t cmd,
    output logic [7:0] rdata
);

    logic [7:0] store_mem [DEPTH];
    logic [7:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            store_mem[cmd.addr] <= cmd.wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rdata_reg <= store_mem[cmd.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/rbs_in_stage.sv]
// Input register stage: holds one request until the core takes it.
module rbs_in_stage
    import rbs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  req_t in_item,
    input  logic take,
    output logic held_valid,
    output req_t held_item
);

    logic held_valid_reg;
    logic held_valid_next;
    req_t held_item_reg;
    logic load;

    // The stage accepts when empty or when its item moves on in this cycle.
    assign in_ready = !held_valid_reg || take;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        held_valid_next = held_valid_reg;
        if (load)
        begin
            held_valid_next = 1'b1;
        end
        else if (take)
        begin
            held_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            held_item_reg <= in_item;
        end
    end

    assign held_valid = held_valid_reg;
    assign held_item  = held_item_reg;

endmodule

[rtl/core/rbs_core.sv]
// Pointer state, operation logic and result register of the ring buffer.
module rbs_core
    import rbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       held_valid,
    input  req_t       held_item,
    output logic       take,
    output mem_cmd_t   mem_cmd,
    input  logic [7:0] mem_rdata,
    output logic       out_valid,
    input  logic       out_ready,
    output rsp_t       out_item
);

    logic [ADDR_W-1:0] rp_reg;
    logic [ADDR_W-1:0] rp_next;
    logic [ADDR_W-1:0] wp_reg;
    logic [ADDR_W-1:0] wp_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;
    logic              peek_reg;
    logic              peek_next;

    logic [ADDR_W-1:0] filled_now;
    logic [CNT_W-1:0]  free_now;
    logic [CNT_W:0]    off_p1;
    logic [CNT_W:0]    off_p2;
    logic [ADDR_W-1:0] rpos;
    logic [ADDR_W-1:0] wpos;
    logic              wr_ok;
    logic              rd_ok;
    logic              wspan_ok;
    logic [CNT_W-1:0]  rd_avail;
    logic [CNT_W-1:0]  rd_to_end;
    logic [CNT_W-1:0]  rd_len1;
    logic [CNT_W-1:0]  rd_left;
    logic [CNT_W-1:0]  wr_to_end;
    logic [ADDR_W-1:0] filled_after;

    // The held request moves on when the result register is empty or its result is taken.
    assign take = held_valid && (!out_valid_reg || out_ready);

    // Occupancy before the operation and the two offset positions.
    assign filled_now = wp_reg - rp_reg;
    assign free_now   = CNT_W'(DEPTH) - {1'b0, filled_now};
    assign off_p1     = {2'b00, held_item.offset} + (CNT_W + 1)'(1);
    assign off_p2     = {2'b00, held_item.offset} + (CNT_W + 1)'(2);
    assign rpos       = rp_reg + held_item.offset;
    assign wpos       = wp_reg + held_item.offset;
    assign wr_ok      = off_p2 <= {1'b0, free_now};
    assign rd_ok      = held_item.offset < filled_now;
    assign wspan_ok   = {1'b0, free_now} > off_p1;

    // Read span pieces: bytes up to the write pointer or up to the end of store.
    assign rd_avail  = {1'b0, wp_reg - rpos};
    assign rd_to_end = CNT_W'(DEPTH) - {1'b0, rpos};
    assign rd_len1   = (held_item.count < rd_to_end) ? held_item.count : rd_to_end;
    assign rd_left   = held_item.count - rd_len1;
    assign wr_to_end = CNT_W'(DEPTH) - {1'b0, wpos};

    // Operation decode: pointer updates, store access and span results.
    always_comb
    begin
        rp_next              = rp_reg;
        wp_next              = wp_reg;
        peek_next            = 1'b0;
        rsp_next             = '0;
        mem_cmd.wr_en        = 1'b0;
        mem_cmd.rd_en        = 1'b0;
        mem_cmd.addr         = rpos;
        mem_cmd.wdata        = held_item.data_in;
        unique case (held_item.op)
            OP_WRITE_BYTE:
            begin
                mem_cmd.addr  = wpos;
                mem_cmd.wr_en = take && wr_ok;
                rsp_next.ok   = wr_ok;
            end
            OP_COMMIT_WRITE:
            begin
                wp_next     = wp_reg + held_item.count[ADDR_W-1:0];
                rsp_next.ok = 1'b1;
            end
            OP_PEEK_BYTE:
            begin
                mem_cmd.rd_en = take && rd_ok;
                peek_next     = rd_ok;
                rsp_next.ok   = rd_ok;
            end
            OP_COMMIT_READ:
            begin
                rp_next     = rp_reg + held_item.count[ADDR_W-1:0];
                rsp_next.ok = 1'b1;
            end
            OP_READ_SPANS:
            begin
                if (held_item.count != '0 && rd_ok)
                begin
                    rsp_next.ok         = 1'b1;
                    rsp_next.span_start = rpos;
                    rsp_next.span_count = 2'd1;
                    if (rpos < wp_reg)
                    begin
                        rsp_next.first_len = (held_item.count < rd_avail) ?
                                             held_item.count : rd_avail;
                    end
                    else
                    begin
                        rsp_next.first_len = rd_len1;
                        if (rd_left != '0 && wp_reg != '0)
                        begin
                            rsp_next.second_len = (rd_left < {1'b0, wp_reg}) ?
                                                  rd_left[ADDR_W-1:0] : wp_reg;
                            rsp_next.span_count = 2'd2;
                        end
                    end
                end
            end
            OP_WRITE_SPANS:
            begin
                if (wspan_ok)
                begin
                    rsp_next.ok         = 1'b1;
                    rsp_next.span_start = wpos;
                    rsp_next.span_count = 2'd1;
                    if (rp_reg > wpos)
                    begin
                        rsp_next.first_len = {1'b0, rp_reg - wpos - ADDR_W'(1)};
                    end
                    else if (rp_reg == '0)
                    begin
                        rsp_next.first_len = wr_to_end - CNT_W'(1);
                    end
                    else
                    begin
                        rsp_next.first_len = wr_to_end;
                        if (rp_reg > ADDR_W'(1))
                        begin
                            rsp_next.second_len = rp_reg - ADDR_W'(1);
                            rsp_next.span_count = 2'd2;
                        end
                    end
                end
            end
            default:
            begin
                rsp_next.ok = 1'b0;
            end
        endcase
        rsp_next.filled     = filled_after;
        rsp_next.free_space = CNT_W'(DEPTH) - {1'b0, filled_after};
    end

    // Occupancy reported after the operation.
    assign filled_after = wp_next - rp_next;

    // Result register valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg        <= '0;
            wp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                rp_reg <= rp_next;
                wp_reg <= wp_next;
            end
        end
    end

    // Result payload; the peek byte arrives from the store's read register.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rsp_reg  <= rsp_next;
            peek_reg <= peek_next;
        end
    end

    always_comb
    begin
        out_item          = rsp_reg;
        out_item.data_out = peek_reg ? mem_rdata : 8'd0;
    end

    assign out_valid = out_valid_reg;

endmodule

[rtl/core/ring_byte_buffer_with_spans.sv]
// Top level of the ring byte buffer with read and write span queries.
//
//  channel | direction | content
//  req     | in        | op, offset, count, data_in
//  rsp     | out       | ok, data_out, filled, free_space, span_count,
//          |           | span_start, first_len, second_len
//
// One request is taken every cycle while the sink takes each result when offered;
// a result passes the input register, then the result register with the store read,
// before the sink can take it. The pointer update and the store access (at most one)
// of an operation happen in the same cycle.
// Reset clears both pointers; store contents are undefined until written.
// A stalled result holds in the result register while one more request waits
// in the input register; the request side stalls only when both are full.
module ring_byte_buffer_with_spans
    import rbs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    rbs_req_if.sink   req,
    rbs_rsp_if.source rsp
);

    req_t     in_item;
    req_t     held_item;
    logic     held_valid;
    logic     take;
    mem_cmd_t mem_cmd;
    logic [7:0] mem_rdata;
    rsp_t     out_item;

    // Gather the request fields into one word.
    always_comb
    begin
        in_item.op      = req.op;
        in_item.offset  = req.offset;
        in_item.count   = req.count;
        in_item.data_in = req.data_in;
    end

    rbs_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req.valid),
        .in_ready   (req.ready),
        .in_item    (in_item),
        .take       (take),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    rbs_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .held_valid (held_valid),
        .held_item  (held_item),
        .take       (take),
        .mem_cmd    (mem_cmd),
        .mem_rdata  (mem_rdata),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .out_item   (out_item)
    );

    rbs_mem u_mem (
        .clk   (clk),
        .cmd   (mem_cmd),
        .rdata (mem_rdata)
    );

    // Spread the result word onto the channel.
    assign rsp.ok         = out_item.ok;
    assign rsp.data_out   = out_item.data_out;
    assign rsp.filled     = out_item.filled;
    assign rsp.free_space = out_item.free_space;
    assign rsp.span_count = out_item.span_count;
    assign rsp.span_start = out_item.span_start;
    assign rsp.first_len  = out_item.first_len;
    assign rsp.second_len = out_item.second_len;

endmodule

[rtl/core/rbs_chk.sv]
// Port checker for the ring byte buffer and its bind to the top level.
module rbs_chk
    import rbs_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic              rsp_ok,
    input logic [7:0]        rsp_data_out,
    input logic [ADDR_W-1:0] rsp_filled,
    input logic [CNT_W-1:0]  rsp_free_space,
    input logic [1:0]        rsp_span_count,
    input logic [ADDR_W-1:0] rsp_span_start,
    input logic [CNT_W-1:0]  rsp_first_len,
    input logic [ADDR_W-1:0] rsp_second_len
);

    // A result waiting for the sink stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    // In every offered result, the filled and free counts add up to the store depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (CNT_W'({1'b0, rsp_filled}) + rsp_free_space) == CNT_W'(DEPTH))
        else $error("filled and free counts disagree");

    // A refused request reports no byte and no spans.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ok |-> rsp_data_out == 8'd0 && rsp_span_count == 2'd0 &&
            rsp_span_start == '0 && rsp_first_len == '0 && rsp_second_len == '0)
        else $error("refused request carries data");

    // A wrapped pair of spans has its first span end at the end of the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_span_count == 2'd2 |->
            (CNT_W'({1'b0, rsp_span_start}) + rsp_first_len) == CNT_W'(DEPTH) &&
            rsp_second_len != '0)
        else $error("wrapped spans do not meet at the end of the store");

endmodule

bind ring_byte_buffer_with_spans rbs_chk u_rbs_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_ok         (rsp.ok),
    .rsp_data_out   (rsp.data_out),
    .rsp_filled     (rsp.filled),
    .rsp_free_space (rsp.free_space),
    .rsp_span_count (rsp.span_count),
    .rsp_span_start (rsp.span_start),
    .rsp_first_len  (rsp.first_len),
    .rsp_second_len (rsp.second_len)
);

[verif/rbs_ring_checker.sv]
`timescale 1ns / 100ps
// Checker that predicts every result of the ring byte buffer and compares it on arrival.
module rbs_ring_checker
    import rbs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    rbs_req_if   req,
    rbs_rsp_if   rsp,
    output int   fail_count,
    output int   pending_results,
    output int   checked_results
);

    logic [7:0]        ring_store [DEPTH];
    logic [ADDR_W-1:0] rd_ptr;
    logic [ADDR_W-1:0] wr_ptr;
    rsp_t              expected_q [$];

    // Applies one request to the predicted ring state and returns its result.
    function automatic rsp_t apply_request(input req_t r);
        rsp_t              res;
        logic [ADDR_W-1:0] slot;
        int unsigned       wp;
        int unsigned       rp;
        int unsigned       off;
        int unsigned       cnt;
        int unsigned       used;
        int unsigned       room;
        int unsigned       pos;
        int unsigned       first;
        int unsigned       second;
        int unsigned       left;
        res    = '0;
        wp     = wr_ptr;
        rp     = rd_ptr;
        off    = r.offset;
        cnt    = r.count;
        used   = (wp - rp) & (DEPTH - 1);
        room   = DEPTH - used;
        first  = 0;
        second = 0;
        case (r.op)
            OP_WRITE_BYTE:
            begin
                // One slot stays empty, so the byte must land short of it.
                if (off + 2 <= room)
                begin
                    slot = wr_ptr + r.offset;
                    ring_store[slot] = r.data_in;
                    res.ok = 1'b1;
                end
            end
            OP_COMMIT_WRITE:
            begin
                wr_ptr = ADDR_W'(wp + cnt);
                res.ok = 1'b1;
            end
            OP_PEEK_BYTE:
            begin
                if (off < used)
                begin
                    slot = rd_ptr + r.offset;
                    res.data_out = ring_store[slot];
                    res.ok = 1'b1;
                end
            end
            OP_COMMIT_READ:
            begin
                rd_ptr = ADDR_W'(rp + cnt);
                res.ok = 1'b1;
            end
            OP_READ_SPANS:
            begin
                // Readable data from the offset, cut by the count and the write pointer.
                if (cnt != 0 && off < used)
                begin
                    pos = (rp + off) & (DEPTH - 1);
                    res.ok = 1'b1;
                    res.span_start = ADDR_W'(pos);
                    res.span_count = 2'd1;
                    if (pos < wp)
                    begin
                        first = (cnt < wp - pos) ? cnt : wp - pos;
                    end
                    else
                    begin
                        first = (cnt < DEPTH - pos) ? cnt : DEPTH - pos;
                        left  = cnt - first;
                        if (left > 0 && wp > 0)
                        begin
                            second = (left < wp) ? left : wp;
                            res.span_count = 2'd2;
                        end
                    end
                end
            end
            OP_WRITE_SPANS:
            begin
                // Free room from the offset up to the slot before the read pointer.
                if (room > off + 1)
                begin
                    pos = (wp + off) & (DEPTH - 1);
                    res.ok = 1'b1;
                    res.span_start = ADDR_W'(pos);
                    res.span_count = 2'd1;
                    if (rp > pos)
                    begin
                        first = rp - pos - 1;
                    end
                    else
                    begin
                        first = DEPTH - pos;
                        if (rp == 0)
                        begin
                            first = first - 1;
                        end
                        else if (rp > 1)
                        begin
                            second = rp - 1;
                            res.span_count = 2'd2;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        res.first_len  = CNT_W'(first);
        res.second_len = ADDR_W'(second);
        used           = (32'(wr_ptr) - 32'(rd_ptr)) & (DEPTH - 1);
        res.filled     = ADDR_W'(used);
        res.free_space = CNT_W'(DEPTH - used);
        return res;
    endfunction

    // Compares one field of a result and reports a difference.
    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // Results are compared before the request of the same edge is predicted,
    // since a result always belongs to an older request.
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        req_t taken;
        if (!rst_n)
        begin
            rd_ptr = '0;
            wr_ptr = '0;
            expected_q.delete();
            fail_count      = 0;
            checked_results = 0;
            pending_results = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result arrived with no request outstanding", $time);
                end
                else
                begin
                    want = expected_q.pop_front();
                    compare_field("ok", 32'(want.ok), 32'(rsp.ok));
                    compare_field("data_out", 32'(want.data_out), 32'(rsp.data_out));
                    compare_field("filled", 32'(want.filled), 32'(rsp.filled));
                    compare_field("free_space", 32'(want.free_space), 32'(rsp.free_space));
                    compare_field("span_count", 32'(want.span_count), 32'(rsp.span_count));
                    compare_field("span_start", 32'(want.span_start), 32'(rsp.span_start));
                    compare_field("first_len", 32'(want.first_len), 32'(rsp.first_len));
                    compare_field("second_len", 32'(want.second_len), 32'(rsp.second_len));
                    checked_results++;
                end
            end
            if (req.valid && req.ready)
            begin
                taken.op      = req.op;
                taken.offset  = req.offset;
                taken.count   = req.count;
                taken.data_in = req.data_in;
                expected_q.push_back(apply_request(taken));
            end
            pending_results = expected_q.size();
        end
    end

endmodule

[verif/tb_ring_byte_buffer_with_spans.sv]
`timescale 1ns / 100ps
// Testbench top that drives requests into the ring byte buffer and reports the verdict.
module tb_ring_byte_buffer_with_spans
    import rbs_pkg::*;
();

    localparam int          CLK_PERIOD   = 10;
    localparam int          TOTAL_ITEMS  = 1750;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          IDLE_LIMIT   = 4000;
    localparam int          DRAIN_CYCLES = 10;
    localparam int          COUNT_MAX    = (1 << CNT_W) - 1;
    localparam logic [2:0]  OP_UNDEFINED = 3'd6;

    logic clk = 1'b0;
    logic rst_n;

    rbs_req_if req_ch ();
    rbs_rsp_if rsp_ch ();

    int fail_count;
    int pending_results;
    int checked_results;

    // Shadow of the pointers and of which slots were ever written, used to shape
    // requests so that no peek reaches an unwritten slot, and for the fill statistics.
    int unsigned wp_shadow;
    int unsigned rp_shadow;
    bit          slot_written [DEPTH];

    // Shared controls for idling and the pressure phases.
    bit quiet_phase;
    bit hold_off_req;
    int rsp_stall;
    int idle_cycles;

    // Run statistics.
    int sent_total;
    int n_writes;
    int n_peeks;
    int n_spans;
    int n_commits;
    int n_other;
    int peak_fill;

    ring_byte_buffer_with_spans u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    rbs_ring_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req_ch),
        .rsp             (rsp_ch),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .checked_results (checked_results)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int unsigned fill_level();
        return (wp_shadow - rp_shadow) & (DEPTH - 1);
    endfunction

    function automatic int unsigned cap_offset(input int unsigned x);
        return (x > DEPTH - 1) ? DEPTH - 1 : x;
    endfunction

    // Drives one request after a random gap and waits until it is accepted.
    // Entered and left at a falling edge.
    task automatic issue(input logic [2:0] op, input int unsigned off,
                         input int unsigned cnt, input int unsigned din);
        int unsigned gap;
        int unsigned level;
        off   = off & (DEPTH - 1);
        cnt   = cnt & COUNT_MAX;
        din   = din & 8'hFF;
        level = fill_level();
        // A peek that would land on a never written slot is moved just past the data.
        if (op == OP_PEEK_BYTE && off < level && !slot_written[ADDR_W'(rp_shadow + off)])
        begin
            off = level;
        end
        gap = quiet_phase ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.op      <= op;
        req_ch.offset  <= ADDR_W'(off);
        req_ch.count   <= CNT_W'(cnt);
        req_ch.data_in <= 8'(din);
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);

        // Keep the shadow in step with the accepted request.
        sent_total++;
        case (op)
            OP_WRITE_BYTE:
            begin
                n_writes++;
                if (off + 2 <= DEPTH - level)
                begin
                    slot_written[ADDR_W'(wp_shadow + off)] = 1'b1;
                end
            end
            OP_COMMIT_WRITE:
            begin
                n_commits++;
                wp_shadow = (wp_shadow + cnt) % DEPTH;
            end
            OP_COMMIT_READ:
            begin
                n_commits++;
                rp_shadow = (rp_shadow + cnt) % DEPTH;
            end
            OP_PEEK_BYTE:   n_peeks++;
            OP_READ_SPANS:  n_spans++;
            OP_WRITE_SPANS: n_spans++;
            default:        n_other++;
        endcase
        if (int'(fill_level()) > peak_fill)
        begin
            peak_fill = fill_level();
        end
    endtask

    // Producer side: write a run of bytes ahead of the write pointer, maybe query the write spans, then commit them.
    task automatic produce_burst();
        int unsigned room;
        int unsigned n;
        room = DEPTH - fill_level() - 1;
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
        if (n > room)
        begin
            n = room;
        end
        for (int unsigned i = 0; i < n; i++)
        begin
            issue(OP_WRITE_BYTE, i, $urandom_range(0, COUNT_MAX), $urandom_range(0, 255));
        end
        if ($urandom_range(0, 1) == 1)
        begin
            issue(OP_WRITE_SPANS, $urandom_range(0, n + 2), $urandom_range(0, COUNT_MAX),
                  $urandom_range(0, 255));
        end
        issue(OP_COMMIT_WRITE, $urandom_range(0, DEPTH - 1), n, $urandom_range(0, 255));
    endtask

    // Consumer side: query the readable spans, peek some bytes, then release some or all of them.
    task automatic consume_burst();
        int unsigned level;
        int unsigned cnt;
        int unsigned m;
        level = fill_level();
        cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, COUNT_MAX)
                                          : $urandom_range(0, level + 2);
        issue(OP_READ_SPANS, cap_offset($urandom_range(0, level + 1)), cnt,
              $urandom_range(0, 255));
        repeat ($urandom_range(0, 6))
        begin
            issue(OP_PEEK_BYTE, cap_offset($urandom_range(0, level)),
                  $urandom_range(0, COUNT_MAX), $urandom_range(0, 255));
        end
        m = ($urandom_range(0, 3) == 0) ? level : $urandom_range(0, level);
        issue(OP_COMMIT_READ, $urandom_range(0, DEPTH - 1), m, $urandom_range(0, 255));
    endtask

    // Unshaped request: any op, including the undefined codes, with wide fields.
    task automatic noise_request();
        int unsigned off;
        int unsigned cnt;
        off = ($urandom_range(0, 1) == 1) ? $urandom_range(0, DEPTH - 1)
                                          : $urandom_range(0, 16);
        case ($urandom_range(0, 3))
            0:       cnt = $urandom_range(0, COUNT_MAX);
            1:       cnt = $urandom_range(0, 16);
            2:       cnt = DEPTH;
            default: cnt = fill_level();
        endcase
        issue(3'($urandom_range(0, 7)), off, cnt, $urandom_range(0, 255));
    endtask

    // Result side: a random stall per result, plus one long hold-off on request.
    initial
    begin
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
            end
            if (rsp_stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                rsp_stall--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            rsp_stall = quiet_phase ? 0 : $urandom_range(0, 3);
        end
    end

    // Watchdog on cycles in which neither channel moves a request or a result.
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (req_ch.valid && req_ch.ready)
            || (rsp_ch.valid && rsp_ch.ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout after %0d cycles without progress", IDLE_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        bit hold_done;
        bit drain_done;
        hold_done      = 1'b0;
        drain_done     = 1'b0;
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.op      = OP_WRITE_BYTE;
        req_ch.offset  = '0;
        req_ch.count   = '0;
        req_ch.data_in = '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty ring, refusals at the edges, both span wraps, full ring,
        // pointer overrun and an undefined op.
        issue(OP_PEEK_BYTE, 0, 0, 0);
        issue(OP_READ_SPANS, 0, 0, 0);
        issue(OP_WRITE_SPANS, 0, 0, 0);
        issue(OP_WRITE_SPANS, DEPTH - 2, 0, 0);
        issue(OP_WRITE_SPANS, DEPTH - 1, 0, 0);
        issue(OP_WRITE_BYTE, DEPTH - 2, 0, 8'hFF);
        issue(OP_WRITE_BYTE, DEPTH - 1, 0, 8'h00);
        issue(OP_WRITE_BYTE, 0, 0, 8'hA5);
        issue(OP_WRITE_BYTE, 1, 0, 8'h5A);
        issue(OP_COMMIT_WRITE, 0, 2, 0);
        issue(OP_PEEK_BYTE, 0, 0, 0);
        issue(OP_PEEK_BYTE, 1, 0, 0);
        issue(OP_READ_SPANS, 0, COUNT_MAX, 0);
        issue(OP_COMMIT_READ, 0, 2, 0);
        issue(OP_WRITE_SPANS, 0, 0, 0);
        issue(OP_COMMIT_WRITE, 0, DEPTH - 2, 0);
        issue(OP_READ_SPANS, 0, COUNT_MAX, 0);
        issue(OP_COMMIT_WRITE, 0, 1, 0);
        issue(OP_READ_SPANS, DEPTH - 3, 10, 0);
        issue(OP_WRITE_BYTE, 0, 0, 8'h3C);
        issue(OP_WRITE_SPANS, 0, 0, 0);
        issue(OP_UNDEFINED, DEPTH - 1, COUNT_MAX, 8'hFF);
        issue(OP_COMMIT_READ, 0, COUNT_MAX, 0);
        issue(OP_WRITE_SPANS, 0, 0, 0);
        issue(OP_COMMIT_WRITE, 0, DEPTH, 0);

        // Random: mostly producer and consumer bursts, some unshaped requests.
        while (sent_total < TOTAL_ITEMS)
        begin
            quiet_phase = ($urandom_range(0, 4) == 0);
            if (!hold_done && sent_total >= 600)
            begin
                hold_off_req = 1'b1;
                hold_done    = 1'b1;
            end
            if (!drain_done && sent_total >= 1200)
            begin
                req_ch.valid <= 1'b0;
                wait (pending_results == 0);
                @(negedge clk);
                drain_done = 1'b1;
            end
            if ($urandom_range(0, 9) < 7)
            begin
                produce_burst();
                consume_burst();
            end
            else
            begin
                repeat ($urandom_range(1, 6)) noise_request();
            end
        end

        req_ch.valid <= 1'b0;
        wait (pending_results == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests: %0d byte writes, %0d peeks, %0d span queries, %0d commits,",
                 sent_total, n_writes, n_peeks, n_spans, n_commits);
        $display("%0d undefined ops; %0d results checked, deepest fill %0d bytes.",
                 n_other, checked_results, peak_fill);
        if (fail_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
